### hdl/nec_ir_frame_transmitter_core_assert.svh
// Assertion macros for the checker file
`ifndef NEC_IR_FRAME_TRANSMITTER_CORE_ASSERT_SVH
`define NEC_IR_FRAME_TRANSMITTER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define NIRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define NIRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/nirt_pkg.sv
// Shared types and constants for the NEC infrared frame transmitter
package nirt_pkg;

  localparam int LenW    = 10;
  localparam int CfgIdxW = 3;
  localparam int BitPosW = 6;
  localparam int FrameW  = 32;

  localparam logic [BitPosW-1:0] FrameBits = BitPosW'(FrameW);

  localparam logic [CfgIdxW-1:0] CFG_LEADER_BURST = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LEADER_PAUSE = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BIT_BURST    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ONE_PAUSE    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ZERO_PAUSE   = 3'd4;

  localparam logic [LenW-1:0] RST_LEADER_BURST = 10'd342;
  localparam logic [LenW-1:0] RST_LEADER_PAUSE = 10'd171;
  localparam logic [LenW-1:0] RST_BIT_BURST    = 10'd22;
  localparam logic [LenW-1:0] RST_ONE_PAUSE    = 10'd64;
  localparam logic [LenW-1:0] RST_ZERO_PAUSE   = 10'd21;

  localparam logic [1:0] STAT_NONE   = 2'd0;
  localparam logic [1:0] STAT_ACCEPT = 2'd1;
  localparam logic [1:0] STAT_REJECT = 2'd2;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_SEND = 1'b1;

  typedef enum logic [5:0] {
    PH_IDLE       = 6'b000001,
    PH_LEAD_BURST = 6'b000010,
    PH_LEAD_PAUSE = 6'b000100,
    PH_BIT_BURST  = 6'b001000,
    PH_BIT_PAUSE  = 6'b010000,
    PH_TERM_BURST = 6'b100000
  } phase_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] address_byte;
    logic [7:0] command_byte;
  } item_t;

  typedef struct packed {
    logic       burst_on;
    logic       busy_res;
    logic [1:0] request_status;
    logic       frame_done;
  } res_t;

  typedef struct packed {
    logic [LenW-1:0] leader_burst;
    logic [LenW-1:0] leader_pause;
    logic [LenW-1:0] bit_burst;
    logic [LenW-1:0] one_pause;
    logic [LenW-1:0] zero_pause;
  } cfg_t;

endpackage

### hdl/nirt_cfg_regs.sv
// Burst and pause length registers with their write port
module nirt_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [nirt_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [nirt_pkg::LenW-1:0]     cfg_wdata,
  output nirt_pkg::cfg_t                cfg
);

  nirt_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.leader_burst <= nirt_pkg::RST_LEADER_BURST;
      cfg_r.leader_pause <= nirt_pkg::RST_LEADER_PAUSE;
      cfg_r.bit_burst    <= nirt_pkg::RST_BIT_BURST;
      cfg_r.one_pause    <= nirt_pkg::RST_ONE_PAUSE;
      cfg_r.zero_pause   <= nirt_pkg::RST_ZERO_PAUSE;
    end else if (cfg_valid) begin
      case (cfg_index)
        nirt_pkg::CFG_LEADER_BURST: cfg_r.leader_burst <= cfg_wdata;
        nirt_pkg::CFG_LEADER_PAUSE: cfg_r.leader_pause <= cfg_wdata;
        nirt_pkg::CFG_BIT_BURST:    cfg_r.bit_burst    <= cfg_wdata;
        nirt_pkg::CFG_ONE_PAUSE:    cfg_r.one_pause    <= cfg_wdata;
        nirt_pkg::CFG_ZERO_PAUSE:   cfg_r.zero_pause   <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

### hdl/nirt_in_stage.sv
// Input register holding one accepted item
module nirt_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  nirt_pkg::item_t in_item,
  input  logic           advance,
  output logic           item_vld,
  output nirt_pkg::item_t item
);

  logic            vld_r;
  nirt_pkg::item_t item_r;

  assign in_ready = !vld_r || advance;
  assign item_vld = vld_r;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

### hdl/nirt_engine.sv
// Frame sequencer: phase, period count, bit position and frame word
module nirt_engine (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            go,
  input  nirt_pkg::item_t item,
  input  nirt_pkg::cfg_t  cfg,
  output nirt_pkg::res_t  res
);

  nirt_pkg::phase_t                 phase_r, phase_nxt;
  logic [nirt_pkg::LenW-1:0]        count_r, count_nxt;
  logic [nirt_pkg::BitPosW-1:0]     bitpos_r, bitpos_nxt;
  logic [nirt_pkg::FrameW-1:0]      frame_r, frame_nxt;
  logic [nirt_pkg::LenW-1:0]        len;
  logic [nirt_pkg::LenW:0]          count_inc;
  logic [nirt_pkg::BitPosW-1:0]     bitpos_inc;
  logic                             active;
  logic                             phase_end;

  assign active     = (phase_r != nirt_pkg::PH_IDLE);
  assign count_inc  = {1'b0, count_r} + {{nirt_pkg::LenW{1'b0}}, 1'b1};
  assign phase_end  = (count_inc >= {1'b0, len});
  assign bitpos_inc = bitpos_r + {{(nirt_pkg::BitPosW-1){1'b0}}, 1'b1};

  always_comb begin
    case (phase_r)
      nirt_pkg::PH_LEAD_BURST: len = cfg.leader_burst;
      nirt_pkg::PH_LEAD_PAUSE: len = cfg.leader_pause;
      nirt_pkg::PH_BIT_BURST:  len = cfg.bit_burst;
      nirt_pkg::PH_TERM_BURST: len = cfg.bit_burst;
      nirt_pkg::PH_BIT_PAUSE:  len = frame_r[bitpos_r[4:0]] ? cfg.one_pause : cfg.zero_pause;
      default:                 len = {{(nirt_pkg::LenW-1){1'b0}}, 1'b1};
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    bitpos_nxt = bitpos_r;
    frame_nxt  = frame_r;
    res        = '0;
    if (go) begin
      if (item.req_type == nirt_pkg::REQ_SEND) begin
        res.busy_res = 1'b1;
        if (active) begin
          res.request_status = nirt_pkg::STAT_REJECT;
        end else begin
          res.request_status = nirt_pkg::STAT_ACCEPT;
          frame_nxt  = {~item.command_byte, item.command_byte,
                        ~item.address_byte, item.address_byte};
          count_nxt  = '0;
          bitpos_nxt = '0;
          phase_nxt  = nirt_pkg::PH_LEAD_BURST;
        end
      end else if (active) begin
        res.busy_res = 1'b1;
        res.burst_on = (phase_r == nirt_pkg::PH_LEAD_BURST) ||
                       (phase_r == nirt_pkg::PH_BIT_BURST) ||
                       (phase_r == nirt_pkg::PH_TERM_BURST);
        if (phase_end) begin
          count_nxt = '0;
          case (phase_r)
            nirt_pkg::PH_LEAD_BURST: phase_nxt = nirt_pkg::PH_LEAD_PAUSE;
            nirt_pkg::PH_LEAD_PAUSE: phase_nxt = nirt_pkg::PH_BIT_BURST;
            nirt_pkg::PH_BIT_BURST:  phase_nxt = nirt_pkg::PH_BIT_PAUSE;
            nirt_pkg::PH_BIT_PAUSE: begin
              bitpos_nxt = bitpos_inc;
              phase_nxt  = (bitpos_inc >= nirt_pkg::FrameBits) ?
                           nirt_pkg::PH_TERM_BURST : nirt_pkg::PH_BIT_BURST;
            end
            default: begin
              phase_nxt      = nirt_pkg::PH_IDLE;
              bitpos_nxt     = '0;
              res.frame_done = 1'b1;
            end
          endcase
        end else begin
          count_nxt = count_inc[nirt_pkg::LenW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= nirt_pkg::PH_IDLE;
      count_r  <= '0;
      bitpos_r <= '0;
      frame_r  <= '0;
    end else begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      bitpos_r <= bitpos_nxt;
      frame_r  <= frame_nxt;
    end
  end

endmodule

### hdl/nirt_out_stage.sv
// Result register facing the output channel
module nirt_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  nirt_pkg::res_t res,
  output logic           room,
  output logic           out_valid,
  input  logic           out_ready,
  output nirt_pkg::res_t out_res
);

  logic           vld_r;
  nirt_pkg::res_t res_r;

  assign room      = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (room) begin
      vld_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

### hdl/nec_ir_frame_transmitter_core.sv
// Top level of the NEC infrared frame transmitter (burst envelope)
//
// Input channel (in_valid/in_ready): in_req_type 1 is a send request with
// in_address_byte and in_command_byte; in_req_type 0 is one carrier-period
// tick. Every transfer in yields exactly one result transfer out.
// Output channel (out_valid/out_ready): out_burst_on, out_busy_res,
// out_request_status (0 none, 1 accepted, 2 rejected while busy), out_frame_done.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index 0..4 selects
// leader burst, leader pause, bit burst, one pause, zero pause lengths in
// ticks; other indexes are dropped. Write only while idle.
// A result passes through the input register, then the result register.
// Throughput: one item per cycle while out_ready is high, set by the
// phase/counter update that the sequencer makes for every item.
// Reset (rst_n low, synchronous) returns to idle, clears the frame state and
// loads the default lengths 342/171/22/64/21.
// When out_ready is low the result register holds; one more item is taken
// into the input register, then in_ready drops until the result is taken.
module nec_ir_frame_transmitter_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [7:0]                    in_address_byte,
  input  logic [7:0]                    in_command_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_burst_on,
  output logic                          out_busy_res,
  output logic [1:0]                    out_request_status,
  output logic                          out_frame_done,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [nirt_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [nirt_pkg::LenW-1:0]     cfg_wdata
);

  nirt_pkg::item_t in_item;
  nirt_pkg::item_t item;
  nirt_pkg::cfg_t  cfg;
  nirt_pkg::res_t  res;
  nirt_pkg::res_t  out_res;
  logic            item_vld;
  logic            room;
  logic            go;

  assign in_item.req_type     = in_req_type;
  assign in_item.address_byte = in_address_byte;
  assign in_item.command_byte = in_command_byte;
  assign go = item_vld && room;

  nirt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  nirt_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .advance  (go),
    .item_vld (item_vld),
    .item     (item)
  );

  nirt_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .item  (item),
    .cfg   (cfg),
    .res   (res)
  );

  nirt_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (go),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_burst_on       = out_res.burst_on;
  assign out_busy_res       = out_res.busy_res;
  assign out_request_status = out_res.request_status;
  assign out_frame_done     = out_res.frame_done;

endmodule

### hdl/nirt_checker.sv
// Port-level checker for the transmitter and its bind
`include "nec_ir_frame_transmitter_core_assert.svh"

module nirt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_burst_on,
  input logic       out_busy_res,
  input logic [1:0] out_request_status,
  input logic       out_frame_done
);

  `NIRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_burst_on) && $stable(out_busy_res) &&
    $stable(out_request_status) && $stable(out_frame_done),
    "result changed while stalled")
  `NIRT_ASSERT_NOW(a_status_code, out_valid, out_request_status != 2'd3,
    "invalid request status")
  `NIRT_ASSERT_NOW(a_burst_busy, out_valid && out_burst_on, out_busy_res,
    "burst without busy")
  `NIRT_ASSERT_NOW(a_done_shape, out_valid && out_frame_done,
    out_busy_res && out_burst_on && (out_request_status == nirt_pkg::STAT_NONE),
    "frame end outside a burst tick")
  `NIRT_ASSERT_NOW(a_req_quiet, out_valid && (out_request_status != nirt_pkg::STAT_NONE),
    out_busy_res && !out_burst_on && !out_frame_done,
    "request result shows carrier")

endmodule

bind nec_ir_frame_transmitter_core nirt_checker u_nirt_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_burst_on       (out_burst_on),
  .out_busy_res       (out_busy_res),
  .out_request_status (out_request_status),
  .out_frame_done     (out_frame_done)
);

### tb/nec_ir_frame_transmitter_core_test.sv
// Self-checking testbench for the NEC infrared frame transmitter core
`timescale 1ns / 100ps

module nec_ir_frame_transmitter_core_test;
  import nirt_pkg::*;

  localparam int StuckLimit = 4000;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_FIRST = 3'd5;

  typedef struct {
    item_t it;
    bit    typed;
    res_t  want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_req_type;
  logic [7:0]          in_address_byte;
  logic [7:0]          in_command_byte;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_burst_on;
  logic                out_busy_res;
  logic [1:0]          out_request_status;
  logic                out_frame_done;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [LenW-1:0]     cfg_wdata;

  cfg_t                lens;
  phase_t              ph;
  logic [LenW-1:0]     cnt;
  logic [BitPosW-1:0]  bpos;
  logic [FrameW-1:0]   word;

  res_t pending_envelopes[$];
  int   errors = 0;
  int   stuck = 0;
  int   stall_pct = 0;
  int   send_idle_pct = 0;

  dir_row_t dir_rows [0:6] = '{
    '{'{REQ_TICK, 8'h00, 8'h00}, 1'b1, '{1'b0, 1'b0, STAT_NONE, 1'b0}},
    '{'{REQ_SEND, 8'h00, 8'hFF}, 1'b1, '{1'b0, 1'b1, STAT_ACCEPT, 1'b0}},
    '{'{REQ_SEND, 8'hFF, 8'h00}, 1'b1, '{1'b0, 1'b1, STAT_REJECT, 1'b0}},
    '{'{REQ_TICK, 8'hFF, 8'hFF}, 1'b1, '{1'b1, 1'b1, STAT_NONE, 1'b0}},
    '{'{REQ_TICK, 8'h00, 8'h00}, 1'b0, '{1'b0, 1'b0, STAT_NONE, 1'b0}},
    '{'{REQ_SEND, 8'hA5, 8'h5A}, 1'b1, '{1'b0, 1'b1, STAT_REJECT, 1'b0}},
    '{'{REQ_TICK, 8'h5A, 8'hA5}, 1'b0, '{1'b0, 1'b0, STAT_NONE, 1'b0}}
  };

  nec_ir_frame_transmitter_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_address_byte    (in_address_byte),
    .in_command_byte    (in_command_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_burst_on       (out_burst_on),
    .out_busy_res       (out_busy_res),
    .out_request_status (out_request_status),
    .out_frame_done     (out_frame_done),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic int phase_length();
    case (ph)
      PH_LEAD_BURST: return int'(lens.leader_burst);
      PH_LEAD_PAUSE: return int'(lens.leader_pause);
      PH_BIT_BURST:  return int'(lens.bit_burst);
      PH_TERM_BURST: return int'(lens.bit_burst);
      PH_BIT_PAUSE:  return word[bpos[4:0]] ? int'(lens.one_pause) : int'(lens.zero_pause);
      default:       return 1;
    endcase
  endfunction

  function automatic res_t advance_frame(item_t it);
    res_t r;
    r = '0;
    if (it.req_type == REQ_SEND) begin
      if (ph != PH_IDLE) begin
        r.request_status = STAT_REJECT;
      end else begin
        word = {~it.command_byte, it.command_byte, ~it.address_byte, it.address_byte};
        cnt = '0;
        bpos = '0;
        ph = PH_LEAD_BURST;
        r.request_status = STAT_ACCEPT;
      end
      r.busy_res = 1'b1;
    end else if (ph != PH_IDLE) begin
      r.busy_res = 1'b1;
      r.burst_on = (ph == PH_LEAD_BURST) || (ph == PH_BIT_BURST) || (ph == PH_TERM_BURST);
      if (int'(cnt) + 1 >= phase_length()) begin
        cnt = '0;
        case (ph)
          PH_LEAD_BURST: ph = PH_LEAD_PAUSE;
          PH_LEAD_PAUSE: ph = PH_BIT_BURST;
          PH_BIT_BURST:  ph = PH_BIT_PAUSE;
          PH_BIT_PAUSE: begin
            bpos = bpos + 1'b1;
            ph = (bpos >= FrameBits) ? PH_TERM_BURST : PH_BIT_BURST;
          end
          default: begin
            ph = PH_IDLE;
            bpos = '0;
            r.frame_done = 1'b1;
          end
        endcase
      end else begin
        cnt = cnt + 1'b1;
      end
    end
    return r;
  endfunction

  function automatic cfg_t uniform_lens(logic [LenW-1:0] v);
    cfg_t c;
    c = '{v, v, v, v, v};
    return c;
  endfunction

  function automatic cfg_t rand_lens(int lo, int hi);
    cfg_t c;
    c.leader_burst = LenW'($urandom_range(hi, lo));
    c.leader_pause = LenW'($urandom_range(hi, lo));
    c.bit_burst    = LenW'($urandom_range(hi, lo));
    c.one_pause    = LenW'($urandom_range(hi, lo));
    c.zero_pause   = LenW'($urandom_range(hi, lo));
    return c;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send_item(item_t it, bit typed, res_t want);
    res_t predicted;
    int   gap = 0;
    in_valid        <= 1'b1;
    in_req_type     <= it.req_type;
    in_address_byte <= it.address_byte;
    in_command_byte <= it.command_byte;
    do @(posedge clk); while (!in_ready);
    predicted = advance_frame(it);
    pending_envelopes.push_back(typed ? want : predicted);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random();
    item_t it;
    it.address_byte = 8'($urandom);
    it.command_byte = 8'($urandom);
    if (ph == PH_IDLE) begin
      it.req_type = ($urandom_range(3) == 0) ? REQ_TICK : REQ_SEND;
    end else begin
      it.req_type = ($urandom_range(29) == 0) ? REQ_SEND : REQ_TICK;
    end
    send_item(it, 1'b0, '0);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_envelopes.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [LenW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_LEADER_BURST: lens.leader_burst = v;
      CFG_LEADER_PAUSE: lens.leader_pause = v;
      CFG_BIT_BURST:    lens.bit_burst    = v;
      CFG_ONE_PAUSE:    lens.one_pause    = v;
      CFG_ZERO_PAUSE:   lens.zero_pause   = v;
      default: ;
    endcase
  endtask

  // shorten every length mid-frame, then tick the frame out
  task automatic drain_frame();
    item_t it;
    if (ph != PH_IDLE) begin
      wait_quiet();
      write_reg(CFG_LEADER_BURST, 10'd1);
      write_reg(CFG_LEADER_PAUSE, 10'd1);
      write_reg(CFG_BIT_BURST, 10'd1);
      write_reg(CFG_ONE_PAUSE, 10'd1);
      write_reg(CFG_ZERO_PAUSE, 10'd1);
      cfg_valid <= 1'b0;
    end
    while (ph != PH_IDLE) begin
      it = '{REQ_TICK, 8'($urandom), 8'($urandom)};
      send_item(it, 1'b0, '0);
    end
  endtask

  task automatic run_phase(cfg_t c, int n, int s_idle, int r_stall);
    wait_quiet();
    write_reg(CFG_LEADER_BURST, c.leader_burst);
    write_reg(CFG_LEADER_PAUSE, c.leader_pause);
    write_reg(CFG_BIT_BURST, c.bit_burst);
    write_reg(CFG_ONE_PAUSE, c.one_pause);
    write_reg(CFG_ZERO_PAUSE, c.zero_pause);
    for (int i = CFG_SPARE_FIRST; i < (1 << CfgIdxW); i++) begin
      write_reg(CfgIdxW'(i), LenW'($urandom));
    end
    cfg_valid <= 1'b0;
    send_idle_pct = s_idle;
    stall_pct = r_stall;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(199) == 0) wait_quiet();
      send_random();
    end
    drain_frame();
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_envelopes.size() == 0) begin
        report_mismatch("result with nothing pending", out_request_status, 0);
      end else begin
        want = pending_envelopes.pop_front();
        if (out_burst_on !== want.burst_on)
          report_mismatch("burst_on", out_burst_on, want.burst_on);
        if (out_busy_res !== want.busy_res)
          report_mismatch("busy_res", out_busy_res, want.busy_res);
        if (out_request_status !== want.request_status)
          report_mismatch("request_status", out_request_status, want.request_status);
        if (out_frame_done !== want.frame_done)
          report_mismatch("frame_done", out_frame_done, want.frame_done);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (!in_valid && pending_envelopes.size() == 0)) begin
      stuck = 0;
    end else if (++stuck >= StuckLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_req_type     = REQ_TICK;
    in_address_byte = '0;
    in_command_byte = '0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_LEADER_BURST;
    cfg_wdata       = '0;
    lens = '{RST_LEADER_BURST, RST_LEADER_PAUSE, RST_BIT_BURST, RST_ONE_PAUSE,
             RST_ZERO_PAUSE};
    ph   = PH_IDLE;
    cnt  = '0;
    bpos = '0;
    word = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
    drain_frame();

    run_phase(uniform_lens(10'd1), 180, 0, 0);
    run_phase(uniform_lens(10'd0), 180, 87, 0);
    run_phase(rand_lens(1, 6), 180, 0, 87);
    run_phase(rand_lens(1, 6), 180, 20, 20);
    run_phase(rand_lens(1, 12), 180, 0, 0);
    run_phase(rand_lens(0, 4), 180, 87, 0);
    run_phase(uniform_lens(10'd1023), 20, 0, 0);
    run_phase(rand_lens(1, 3), 180, 0, 87);
    run_phase(rand_lens(1, 5), 180, 20, 20);

    wait_quiet();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/nirt_pkg.sv
hdl/nirt_cfg_regs.sv
hdl/nirt_in_stage.sv
hdl/nirt_engine.sv
hdl/nirt_out_stage.sv
hdl/nec_ir_frame_transmitter_core.sv
hdl/nirt_checker.sv
tb/nec_ir_frame_transmitter_core_test.sv
